### sv/lrusc_pkg.sv
// Shared constants and types of the LRU set-associative cache simulator.
`timescale 1ns / 1ps

package lrusc_pkg;

	// Default sizes of the cache model.
	localparam int DEF_MAX_SET_BITS = 4;
	localparam int DEF_MAX_WAYS     = 4;
	localparam int DEF_ADDR_BITS    = 64;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

	// Configuration reset values.
	localparam logic [2:0] RST_SET_BITS    = 3'd4;
	localparam logic [5:0] RST_OFFSET_BITS = 6'd4;
	localparam logic [2:0] RST_WAYS_IN_USE = 3'd1;

	// Access kinds.
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE
	} state_t;

endpackage

### sv/lrusc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lrusc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/lru_set_associative_cache_sim_unit.sv
// Top level of the LRU set-associative cache simulator.
// Each accepted access (start high while busy is low) splits the address into set and
// tag, walks the ways in use of that set one line per cycle through a single line RAM,
// then walks them again to write back tags, valid bits and LRU ages. Busy stays high
// through the scan sweep, the decide state and the update sweep, so no new access is
// taken before the last one is through; the two sweeps over the one RAM read port set
// the length of an access. The result appears for exactly one cycle with done high,
// in the first cycle after busy falls, and cannot be held off: it must be taken in
// that cycle. After reset, busy stays high while every line of the line RAM is
// cleared; configuration writes are taken at all times and must only be made while
// no access is in flight.
`timescale 1ns / 1ps

module lru_set_associative_cache_sim_unit #(
	parameter int MAX_SET_BITS = lrusc_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = lrusc_pkg::DEF_MAX_WAYS,
	parameter int ADDR_BITS    = lrusc_pkg::DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           command,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	output logic                 done,
	output logic                 hit,
	output logic                 miss,
	output logic                 eviction,
	output logic                 second_hit,
	output logic [31:0]          hits_total,
	output logic [31:0]          misses_total,
	output logic [31:0]          evictions_total
);

	localparam int NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
	localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam logic [WAY_W-1:0] AGE_MAX = WAY_W'(MAX_WAYS - 1);

	typedef struct packed {
		logic                 valid;
		logic [WAY_W-1:0]     age;
		logic [ADDR_BITS-1:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] inc);
		logic [32:0] sum;
		sum = {1'b0, v} + 33'(inc);
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// Configuration registers.
	logic [2:0] set_bits_q;
	logic [5:0] offset_bits_q;
	logic [2:0] ways_in_use_q;

	// Sequencer and per-access registers.
	lrusc_pkg::state_t state_q, state_d;
	logic [LINE_W-1:0]    clr_idx_q;
	logic [WAY_W-1:0]     k_q;
	logic                 issued_all_q;
	logic                 rd_en_s1;
	logic [WAY_W-1:0]     rd_way_s1;
	logic [1:0]           cmd_q;
	logic [SET_W-1:0]     set_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic                 found_q;
	logic [WAY_W-1:0]     found_way_q;
	logic [WAY_W-1:0]     ref_age_q;
	logic                 empty_q;
	logic [WAY_W-1:0]     empty_way_q;
	logic [WAY_W-1:0]     best_age_q;
	logic [WAY_W-1:0]     best_way_q;
	logic                 hit_q;
	logic                 evict_q;
	logic [WAY_W-1:0]     target_q;
	logic                 done_q;
	logic                 res_hit_q;
	logic                 res_evict_q;
	logic                 res_second_q;
	logic [31:0]          hits_q;
	logic [31:0]          misses_q;
	logic [31:0]          evictions_q;

	// Combinational signals.
	logic [2:0]           s_eff;
	logic [WCNT_W-1:0]    ways_eff;
	logic [WAY_W-1:0]     ways_m1;
	logic [6:0]           shamt;
	logic [SET_W-1:0]     set_mask;
	logic [SET_W-1:0]     set_new;
	logic [ADDR_BITS-1:0] tag_new;
	logic                 accept;
	logic                 issue;
	logic                 last_beat;
	logic                 ram_we;
	logic [LINE_W-1:0]    ram_waddr;
	entry_t               ram_wdata;
	logic [LINE_W-1:0]    ram_raddr;
	entry_t               ram_rdata;
	logic [ENTRY_W-1:0]   ram_rdata_raw;
	entry_t               upd_entry;
	logic                 second;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != lrusc_pkg::ST_IDLE);
	assign accept    = start && !busy;

	// Out-of-range settings fold onto the nearest legal value.
	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			s_eff = 3'(MAX_SET_BITS);
		end else begin
			s_eff = set_bits_q;
		end
		if (ways_in_use_q == 3'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(ways_in_use_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_in_use_q);
		end
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (i < int'(s_eff));
		end
	end

	assign ways_m1 = WAY_W'(ways_eff - WCNT_W'(1));
	assign shamt   = 7'(offset_bits_q) + 7'(s_eff);
	// A shift past the address width leaves a zero tag, as a wide split requires.
	assign tag_new = address >> shamt;
	assign set_new = SET_W'(address >> offset_bits_q) & set_mask;

	assign ram_rdata = entry_t'(ram_rdata_raw);
	assign last_beat = rd_en_s1 && (rd_way_s1 == ways_m1);
	assign ram_raddr = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(k_q);
	assign second    = (cmd_q == lrusc_pkg::CMD_MODIFY);

	// New contents of the line read back during the update sweep.
	always_comb begin
		upd_entry = ram_rdata;
		if (rd_way_s1 == target_q) begin
			upd_entry.valid = 1'b1;
			upd_entry.age   = '0;
			if (!hit_q) begin
				upd_entry.tag = tag_q;
			end
		end else if (ram_rdata.valid && (!hit_q || ram_rdata.age < ref_age_q)
				&& ram_rdata.age != AGE_MAX) begin
			upd_entry.age = ram_rdata.age + WAY_W'(1);
		end
	end

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(rd_way_s1);
		ram_wdata = upd_entry;
		case (state_q)
			lrusc_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
				if (clr_idx_q == LINE_W'(NUM_LINES - 1)) begin
					state_d = lrusc_pkg::ST_IDLE;
				end
			end
			lrusc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lrusc_pkg::ST_SCAN;
				end
			end
			lrusc_pkg::ST_SCAN: begin
				issue = !issued_all_q;
				if (last_beat) begin
					state_d = lrusc_pkg::ST_DECIDE;
				end
			end
			lrusc_pkg::ST_DECIDE: begin
				state_d = lrusc_pkg::ST_UPDATE;
			end
			lrusc_pkg::ST_UPDATE: begin
				issue  = !issued_all_q;
				ram_we = rd_en_s1;
				if (last_beat) begin
					state_d = lrusc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrusc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrusc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= lrusc_pkg::RST_SET_BITS;
			offset_bits_q <= lrusc_pkg::RST_OFFSET_BITS;
			ways_in_use_q <= lrusc_pkg::RST_WAYS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lrusc_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				lrusc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				lrusc_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Sweep control: k_q issues reads, the _s1 stage marks the beat whose data is back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q    <= '0;
			k_q          <= '0;
			issued_all_q <= 1'b0;
			rd_en_s1     <= 1'b0;
			rd_way_s1    <= '0;
			done_q       <= 1'b0;
			hits_q       <= '0;
			misses_q     <= '0;
			evictions_q  <= '0;
		end else begin
			done_q   <= (state_q == lrusc_pkg::ST_UPDATE) && last_beat;
			rd_en_s1 <= issue;
			if (state_q == lrusc_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + LINE_W'(1);
			end
			if (issue) begin
				rd_way_s1 <= k_q;
				if (k_q == ways_m1) begin
					issued_all_q <= 1'b1;
				end else begin
					k_q <= k_q + WAY_W'(1);
				end
			end
			if (accept || state_q == lrusc_pkg::ST_DECIDE) begin
				k_q          <= '0;
				issued_all_q <= 1'b0;
			end
			if (state_q == lrusc_pkg::ST_UPDATE && last_beat) begin
				hits_q <= sat_add(hits_q, 2'(hit_q) + 2'(second));
				if (!hit_q) begin
					misses_q <= sat_add(misses_q, 2'd1);
				end
				if (evict_q) begin
					evictions_q <= sat_add(evictions_q, 2'd1);
				end
			end
		end
	end

	// Per-access datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= command;
			set_q       <= set_new;
			tag_q       <= tag_new;
			found_q     <= 1'b0;
			found_way_q <= '0;
			ref_age_q   <= '0;
			empty_q     <= 1'b0;
			empty_way_q <= '0;
			best_age_q  <= '0;
			best_way_q  <= '0;
		end
		if (state_q == lrusc_pkg::ST_SCAN && rd_en_s1) begin
			if (ram_rdata.valid) begin
				if (!found_q && ram_rdata.tag == tag_q) begin
					found_q     <= 1'b1;
					found_way_q <= rd_way_s1;
					ref_age_q   <= ram_rdata.age;
				end
			end else if (!empty_q) begin
				empty_q     <= 1'b1;
				empty_way_q <= rd_way_s1;
			end
			if (ram_rdata.age > best_age_q) begin
				best_age_q <= ram_rdata.age;
				best_way_q <= rd_way_s1;
			end
		end
		if (state_q == lrusc_pkg::ST_DECIDE) begin
			hit_q   <= found_q;
			evict_q <= !found_q && !empty_q;
			if (found_q) begin
				target_q <= found_way_q;
			end else if (empty_q) begin
				target_q <= empty_way_q;
			end else begin
				target_q <= best_way_q;
			end
		end
		if (state_q == lrusc_pkg::ST_UPDATE && last_beat) begin
			res_hit_q    <= hit_q;
			res_evict_q  <= evict_q;
			res_second_q <= second;
		end
	end

	lrusc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_LINES)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign done            = done_q;
	assign hit             = res_hit_q;
	assign miss            = !res_hit_q;
	assign eviction        = res_evict_q;
	assign second_hit      = res_second_q;
	assign hits_total      = hits_q;
	assign misses_total    = misses_q;
	assign evictions_total = evictions_q;

`ifndef SYNTH
	// A result only follows the last write-back beat of an update sweep.
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == lrusc_pkg::ST_UPDATE))
		else $error("result strobe without a finished update sweep");

	// An eviction is always a miss.
	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && eviction) |-> miss)
		else $error("eviction reported on a hit");

	// The line RAM is written only while clearing or writing back.
	a_ram_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == lrusc_pkg::ST_CLEAR || state_q == lrusc_pkg::ST_UPDATE))
		else $error("line RAM written outside clear or update");

	// The miss total does not move on a reported hit.
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> $stable(misses_total))
		else $error("miss total changed on a hit");
`endif

endmodule

### tb/lru_set_associative_cache_sim_unit_test.sv
// Self-checking testbench of the LRU set-associative cache simulator top level.
`timescale 1ns / 1ps

module lru_set_associative_cache_sim_unit_test;

	localparam int         LINE_COUNT     =
		(1 << lrusc_pkg::DEF_MAX_SET_BITS) * lrusc_pkg::DEF_MAX_WAYS;
	localparam int         OLDEST_AGE     = lrusc_pkg::DEF_MAX_WAYS - 1;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         REPORT_LIMIT   = 10;
	localparam int         PHASE_ITEMS    = 90;
	localparam int         PHASE_COUNT    = 10;
	localparam logic [1:0] CMD_RESERVED   = 2'd3;
	localparam logic [1:0] CFG_NO_REG     = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] addr;
	} cache_access_t;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic        eviction;
		logic        second_hit;
		logic [31:0] hits_total;
		logic [31:0] misses_total;
		logic [31:0] evictions_total;
	} access_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  command    = '0;
	logic [63:0] address    = '0;
	logic        cfg_valid  = 1'b0;
	logic [1:0]  cfg_index  = '0;
	logic [5:0]  cfg_data   = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic        hit;
	logic        miss;
	logic        eviction;
	logic        second_hit;
	logic [31:0] hits_total;
	logic [31:0] misses_total;
	logic [31:0] evictions_total;

	// Shadow copy of the cache: settings, lines and running totals.
	logic [2:0]  shadow_set_bits    = lrusc_pkg::RST_SET_BITS;
	logic [5:0]  shadow_offset_bits = lrusc_pkg::RST_OFFSET_BITS;
	logic [2:0]  shadow_ways        = lrusc_pkg::RST_WAYS_IN_USE;
	logic [63:0] shadow_tag   [LINE_COUNT];
	bit          shadow_valid [LINE_COUNT];
	logic [1:0]  shadow_age   [LINE_COUNT];
	logic [31:0] shadow_hits      = '0;
	logic [31:0] shadow_misses    = '0;
	logic [31:0] shadow_evictions = '0;

	cache_access_t  pending_accesses [$];
	access_result_t predicted_results [$];

	int unsigned queued_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned settings_count = 0;
	int unsigned idle_cycles    = 0;
	int unsigned sender_idle_pct = 0;
	bit          item_taken     = 1'b0;

	lru_set_associative_cache_sim_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.address         (address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.hit             (hit),
		.miss            (miss),
		.eviction        (eviction),
		.second_hit      (second_hit),
		.hits_total      (hits_total),
		.misses_total    (misses_total),
		.evictions_total (evictions_total)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] bump(logic [31:0] count);
		return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
	endfunction

	function automatic int effective_set_bits();
		return (int'(shadow_set_bits) > lrusc_pkg::DEF_MAX_SET_BITS)
			? lrusc_pkg::DEF_MAX_SET_BITS : int'(shadow_set_bits);
	endfunction

	// Make one way the most recent; on a fill every other valid way not yet at the oldest age ages.
	function automatic void promote_line(int base, int ways, int way, bit fill);
		int k;
		logic [1:0] ref_age;
		ref_age = shadow_age[base + way];
		for (k = 0; k < ways; k++) begin
			if (k != way && shadow_valid[base + k]) begin
				if (fill || shadow_age[base + k] < ref_age) begin
					if (int'(shadow_age[base + k]) < OLDEST_AGE)
						shadow_age[base + k] = shadow_age[base + k] + 2'd1;
				end
			end
		end
		shadow_age[base + way] = '0;
	endfunction

	function automatic access_result_t predict_access(logic [1:0] cmd, logic [63:0] addr);
		int s;
		int b;
		int ways;
		int set_idx;
		int base;
		int found;
		int empty;
		int victim;
		int k;
		logic [1:0] best;
		logic [63:0] tag;
		access_result_t r;
		s = effective_set_bits();
		b = int'(shadow_offset_bits);
		ways = int'(shadow_ways);
		if (ways == 0)
			ways = 1;
		if (ways > lrusc_pkg::DEF_MAX_WAYS)
			ways = lrusc_pkg::DEF_MAX_WAYS;
		set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
		tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
		base = set_idx * lrusc_pkg::DEF_MAX_WAYS;
		found = -1;
		empty = -1;
		for (k = 0; k < ways; k++) begin
			if (shadow_valid[base + k]) begin
				if (found < 0 && shadow_tag[base + k] == tag)
					found = k;
			end else if (empty < 0) begin
				empty = k;
			end
		end
		r = '0;
		if (found >= 0) begin
			r.hit = 1'b1;
			promote_line(base, ways, found, 1'b0);
		end else begin
			r.miss = 1'b1;
			if (empty >= 0) begin
				victim = empty;
			end else begin
				// Oldest way goes; on equal ages the lowest way wins.
				best = '0;
				victim = 0;
				for (k = 0; k < ways; k++) begin
					if (shadow_age[base + k] > best) begin
						best = shadow_age[base + k];
						victim = k;
					end
				end
				r.eviction = 1'b1;
			end
			shadow_tag[base + victim] = tag;
			shadow_valid[base + victim] = 1'b1;
			promote_line(base, ways, victim, 1'b1);
		end
		if (r.hit)
			shadow_hits = bump(shadow_hits);
		else
			shadow_misses = bump(shadow_misses);
		if (r.eviction)
			shadow_evictions = bump(shadow_evictions);
		if (cmd == lrusc_pkg::CMD_MODIFY) begin
			r.second_hit = 1'b1;
			shadow_hits = bump(shadow_hits);
		end
		r.hits_total = shadow_hits;
		r.misses_total = shadow_misses;
		r.evictions_total = shadow_evictions;
		return r;
	endfunction

	function automatic string describe(access_result_t r);
		return $sformatf("hit %0b miss %0b eviction %0b second_hit %0b totals %0d/%0d/%0d",
			r.hit, r.miss, r.eviction, r.second_hit,
			r.hits_total, r.misses_total, r.evictions_total);
	endfunction

	// Builds an address from tag, set and random offset under the current split.
	function automatic logic [63:0] compose_address(logic [63:0] tag, logic [3:0] set_idx,
			logic [63:0] noise);
		int s;
		int b;
		logic [63:0] a;
		s = effective_set_bits();
		b = int'(shadow_offset_bits);
		a = noise & ((64'd1 << b) - 64'd1);
		a = a | ((64'(set_idx) & ((64'd1 << s) - 64'd1)) << b);
		if (s + b < 64)
			a = a | (tag << (s + b));
		return a;
	endfunction

	// Driver: one access beat per accepted start, held while busy.
	always @(negedge clk) begin : access_driver
		cache_access_t next_access;
		if (!start || item_taken) begin
			if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				next_access = pending_accesses.pop_front();
				start <= 1'b1;
				command <= next_access.cmd;
				address <= next_access.addr;
			end else begin
				start <= 1'b0;
				command <= 2'($urandom);
				address <= {$urandom, $urandom};
			end
		end
	end

	// Monitor: checks result beats, tracks register writes and accepted accesses.
	always @(posedge clk) begin : result_monitor
		bit activity;
		access_result_t seen;
		access_result_t wanted;
		if (arst_n) begin
			activity = 1'b0;
			if (done) begin
				activity = 1'b1;
				seen = {hit, miss, eviction, second_hit, hits_total, misses_total,
					evictions_total};
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("Unexpected result beat: %s", describe(seen));
				end else begin
					wanted = predicted_results.pop_front();
					if (seen !== wanted) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("Mismatch at %0t", $realtime);
							$display("  expected %s", describe(wanted));
							$display("  actual   %s", describe(seen));
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				activity = 1'b1;
				case (cfg_index)
					lrusc_pkg::CFG_SET_BITS:    shadow_set_bits = cfg_data[2:0];
					lrusc_pkg::CFG_OFFSET_BITS: shadow_offset_bits = cfg_data;
					lrusc_pkg::CFG_WAYS_IN_USE: shadow_ways = cfg_data[2:0];
					default: ;
				endcase
			end
			item_taken = start && !busy;
			if (item_taken) begin
				activity = 1'b1;
				accepted_count++;
				predicted_results.push_back(predict_access(command, address));
			end
			if (activity) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
						idle_cycles, predicted_results.size());
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	task automatic queue_access(logic [1:0] cmd, logic [63:0] addr);
		cache_access_t a;
		a.cmd = cmd;
		a.addr = addr;
		queued_count++;
		pending_accesses.push_back(a);
	endtask

	// Returns once every queued access is accepted and answered.
	task automatic settle();
		while (accepted_count != queued_count || predicted_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last beat.
	task automatic write_register(logic [1:0] idx, logic [5:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(int s, int b, int w);
		write_register(lrusc_pkg::CFG_SET_BITS, {3'($urandom), 3'(s)});
		write_register(lrusc_pkg::CFG_OFFSET_BITS, 6'(b));
		write_register(lrusc_pkg::CFG_WAYS_IN_USE, {3'($urandom), 3'(w)});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	initial begin : stimulus
		int phase_set_bits [PHASE_COUNT]    = '{4, 0, 2, 7, 1, 3, 4, 4, 0, 2};
		int phase_offset_bits [PHASE_COUNT] = '{4, 0, 6, 3, 32, 63, 58, 60, 0, 1};
		int phase_ways [PHASE_COUNT]        = '{4, 4, 2, 3, 7, 4, 0, 4, 0, 1};
		logic [63:0] tag_pool [6];
		logic [3:0] hot_set;
		logic [3:0] set_idx;
		int p;
		int n;
		int i;
		for (i = 0; i < LINE_COUNT; i++) begin
			shadow_tag[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_age[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_count = 1;

		// Reset split, one way: hits, modify, the reserved command, eviction.
		sender_idle_pct = 33;
		queue_access(lrusc_pkg::CMD_LOAD, 64'h0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'hF);
		queue_access(lrusc_pkg::CMD_STORE, 64'h0);
		queue_access(lrusc_pkg::CMD_MODIFY, 64'h0);
		queue_access(CMD_RESERVED, 64'h0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h100);
		queue_access(lrusc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_access(lrusc_pkg::CMD_STORE, 64'h8000_0000_0000_0000);
		settle();

		// One set, no offset, oversized associativity: fill, evict, reuse.
		apply_settings(0, 0, 7);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h1);
		queue_access(lrusc_pkg::CMD_STORE, 64'h2);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h3);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h1);
		queue_access(lrusc_pkg::CMD_MODIFY, 64'h4);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h1);
		settle();

		// Split wider than the address, so every tag is zero; ways of zero acts as one.
		apply_settings(7, 63, 0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h0);
		queue_access(lrusc_pkg::CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
		queue_access(lrusc_pkg::CMD_STORE, 64'h8000_0000_0000_0000);
		queue_access(lrusc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		settle();

		// A write to the unused index must change nothing.
		write_register(CFG_NO_REG, 6'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;

		for (p = 0; p < PHASE_COUNT; p++) begin
			settle();
			if (p == 8)
				apply_settings($urandom_range(0, 7), $urandom_range(0, 63),
					$urandom_range(0, 7));
			else
				apply_settings(phase_set_bits[p], phase_offset_bits[p], phase_ways[p]);
			sender_idle_pct = (p < 3) ? 33 : (p < 6) ? 59 : 0;
			tag_pool[0] = '0;
			tag_pool[1] = 64'd1;
			tag_pool[2] = '1;
			for (i = 3; i < 6; i++)
				tag_pool[i] = {$urandom, $urandom};
			hot_set = 4'($urandom);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					// Mostly a few tags over two sets, so lines get reused and evicted.
					if ($urandom_range(0, 99) < 70)
						set_idx = hot_set + 4'($urandom_range(0, 1));
					else
						set_idx = 4'($urandom);
					queue_access(2'($urandom_range(0, 3)),
						compose_address(tag_pool[$urandom_range(0, 5)], set_idx,
							{$urandom, $urandom}));
				end else begin
					queue_access(2'($urandom_range(0, 3)), {$urandom, $urandom});
				end
			end
		end
		settle();
		repeat (20) @(negedge clk);

		if (predicted_results.size() != 0) begin
			mismatch_count += predicted_results.size();
			$display("%0d expected results never arrived", predicted_results.size());
		end
		$display("Run covered %0d accesses over %0d cache settings, from one set to 16 and",
			accepted_count, settings_count);
		$display("one way to four; predicted %0d hits, %0d misses, %0d evictions.",
			shadow_hits, shadow_misses, shadow_evictions);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### lru_set_associative_cache_sim_unit.f
sv/lrusc_pkg.sv
sv/lrusc_ram.sv
sv/lru_set_associative_cache_sim_unit.sv
tb/lru_set_associative_cache_sim_unit_test.sv
